// ===== src/fpt_pkg.sv =====
// Shared types and constants for the frame pacing throttle.
`default_nettype none

package fpt_pkg;

   // Field widths
   localparam int TIME_W     = 32;
   localparam int RATE_W     = 10;
   localparam int SYNC_W     = 5;
   localparam int DUR_W      = 16;
   localparam int GROUP_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // Loop rate search: base + RATE_STEP * k, k = 0 .. RATE_TRY_LAST
   localparam int CAND_W = 11;
   localparam int K_W    = 4;
   localparam logic [CAND_W-1:0] RATE_STEP     = 11'd20;
   localparam logic [K_W-1:0]    RATE_TRY_LAST = 4'd10;

   localparam logic [RATE_W-1:0] RATE_DEFAULT = 10'd60;
   localparam logic [SYNC_W-1:0] SYNC_DEFAULT = 5'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOGIC_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_GROUP = 2'd2;

   // Shared divider
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 16;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } fpt_div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } fpt_div_rsp_type;

   typedef enum logic [3:0] {
      S_DRV_LR,   // candidate % logic rate
      S_DRV_FR,   // candidate % frame rate
      S_DRV_LD,   // loop duration
      S_DRV_GD,   // group duration
      S_IDLE,
      S_LOGIC,    // loop_count % logic_interval
      S_FRAME,    // loop_count % frame_interval
      S_CALC,     // elapsed time, group select, window check
      S_COMMIT    // delay, debt, counters, result
   } fpt_state_type;

endpackage

`default_nettype wire

// ===== src/fpt_if.sv =====
// Request and response channel interfaces of the frame pacing throttle.
`default_nettype none

interface fpt_req_if;
   logic                       valid;
   logic                       ready;
   logic [fpt_pkg::TIME_W-1:0] now_ms;
   logic [fpt_pkg::TIME_W-1:0] resume_ms;

   modport source (output valid, now_ms, resume_ms, input ready);
   modport sink   (input valid, now_ms, resume_ms, output ready);
endinterface

interface fpt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       do_logic;
   logic                       do_render;
   logic [fpt_pkg::DUR_W-1:0]  delay_ms;
   logic                       skip_next;
   logic                       stats_valid;
   logic [fpt_pkg::TIME_W-1:0] loops_per_sec;
   logic [fpt_pkg::TIME_W-1:0] logic_per_sec;
   logic [fpt_pkg::TIME_W-1:0] frames_per_sec;
   logic [fpt_pkg::TIME_W-1:0] skips_per_sec;

   modport source (output valid, do_logic, do_render, delay_ms, skip_next, stats_valid,
                   loops_per_sec, logic_per_sec, frames_per_sec, skips_per_sec,
                   input ready);
   modport sink   (input valid, do_logic, do_render, delay_ms, skip_next, stats_valid,
                   loops_per_sec, logic_per_sec, frames_per_sec, skips_per_sec,
                   output ready);
endinterface

`default_nettype wire

// ===== src/fpt_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module fpt_div (
   input  logic                     clock,
   input  logic                     reset,
   input  fpt_pkg::fpt_div_req_type div_req,
   output fpt_pkg::fpt_div_rsp_type div_rsp
);

   localparam int NumW = fpt_pkg::DIVIDEND_W;
   localparam int DenW = fpt_pkg::DIVISOR_W;
   localparam int CntW = fpt_pkg::DIV_CNT_W;
   localparam logic [CntW-1:0] CntLast = CntW'(NumW - 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [NumW-1:0] quo_ff, quo_in;
   logic [DenW-1:0] rem_ff, rem_in;
   logic [DenW-1:0] dvs_ff, dvs_in;

   logic [DenW:0]   rem_shift;
   logic [DenW:0]   diff;
   logic            ge;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[NumW-1]};
      diff      = rem_shift - {1'b0, dvs_ff};
      ge        = rem_shift >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (div_req.start) begin
         // a new start aborts whatever was in flight
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NumW-2:0], ge};
         rem_in = ge ? diff[DenW-1:0] : rem_shift[DenW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntLast) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== src/frame_pacing_throttle_top.sv =====
// Top level of the frame pacing throttle: sequencer, pacing state and result register.
`default_nettype none

// Paces a game main loop. Each req transaction is one finished loop (its end time and the
// time the next loop resumes); each rsp transaction says whether logic and render ran this
// loop, how long to wait, whether the next frame is skipped, and, once per second, the
// counts of the closed window. All arithmetic that needs a division goes through a single
// radix-2 divider that produces one quotient bit per cycle, so a loop runs as two 32-step
// divisions (loop count modulo the logic and frame intervals), then a step that forms
// elapsed time and picks the loop or group timing, then a step that commits delay, debt
// and counters into the output register. The next transaction is taken while a result
// still waits on rsp. After reset and after every csr write the loop rate, intervals and
// durations are derived again on the same divider: two divisions per rate candidate (up
// to eleven candidates) plus two for the durations, at most 24 divisions, and req stays
// not ready until that finishes. Counters are kept across csr writes.
module frame_pacing_throttle_top #(
   parameter int unsigned MS_PER_SECOND = 1000
) (
   input  logic                                clock,
   input  logic                                reset,
   fpt_req_if.sink                             req_ch,
   fpt_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [fpt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fpt_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int TimeW  = fpt_pkg::TIME_W;
   localparam int RateW  = fpt_pkg::RATE_W;
   localparam int SyncW  = fpt_pkg::SYNC_W;
   localparam int DurW   = fpt_pkg::DUR_W;
   localparam int GroupW = fpt_pkg::GROUP_W;
   localparam int CandW  = fpt_pkg::CAND_W;
   localparam int KW     = fpt_pkg::K_W;
   localparam int NumW   = fpt_pkg::DIVIDEND_W;
   localparam int DenW   = fpt_pkg::DIVISOR_W;
   localparam int MsW    = $clog2(MS_PER_SECOND + 1);
   localparam int ProdW  = MsW + SyncW;
   localparam int DlyW   = TimeW + 2;

   // ---------------------------------------------------------------- state
   fpt_pkg::fpt_state_type state_ff, state_in;
   logic                   issued_ff, issued_in;   // divider op launched for this state

   // configuration
   logic [RateW-1:0]  cfg_lr_ff, cfg_lr_in;
   logic [RateW-1:0]  cfg_fr_ff, cfg_fr_in;
   logic [SyncW-1:0]  cfg_sg_ff, cfg_sg_in;

   // derived rate state
   logic [KW-1:0]     k_ff, k_in;
   logic              lfit_ff, lfit_in;
   logic [DurW-1:0]   li_ff, li_in;
   logic [DurW-1:0]   fi_ff, fi_in;
   logic [DurW-1:0]   ld_ff, ld_in;
   logic [DurW-1:0]   gd_ff, gd_in;

   // pacing state
   logic [TimeW-1:0]  loop_count_ff, loop_count_in;
   logic [TimeW-1:0]  logic_count_ff, logic_count_in;
   logic [TimeW-1:0]  frame_count_ff, frame_count_in;
   logic [TimeW-1:0]  skip_count_ff, skip_count_in;
   logic [TimeW-1:0]  debt_ff, debt_in;
   logic              skip_ff, skip_in;
   logic [GroupW-1:0] group_count_ff, group_count_in;
   logic [TimeW-1:0]  group_start_ff, group_start_in;
   logic [TimeW-1:0]  loop_start_ff, loop_start_in;
   logic [TimeW-1:0]  window_start_ff, window_start_in;

   // per-transaction working registers
   logic [TimeW-1:0]  now_ff, now_in;
   logic [TimeW-1:0]  resume_ff, resume_in;
   logic              logic_hit_ff, logic_hit_in;
   logic              render_hit_ff, render_hit_in;
   logic              grp_ff, grp_in;
   logic [DurW-1:0]   dur_ff, dur_in;
   logic [TimeW-1:0]  elapsed_ff, elapsed_in;
   logic              win_hit_ff, win_hit_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_do_logic_ff, rsp_do_logic_in;
   logic              rsp_do_render_ff, rsp_do_render_in;
   logic [DurW-1:0]   rsp_delay_ff, rsp_delay_in;
   logic              rsp_skip_next_ff, rsp_skip_next_in;
   logic              rsp_stats_ff, rsp_stats_in;
   logic [TimeW-1:0]  rsp_loops_ff, rsp_loops_in;
   logic [TimeW-1:0]  rsp_logic_ff, rsp_logic_in;
   logic [TimeW-1:0]  rsp_frames_ff, rsp_frames_in;
   logic [TimeW-1:0]  rsp_skips_ff, rsp_skips_in;

   // ---------------------------------------------------------------- divider
   fpt_pkg::fpt_div_req_type div_req;
   fpt_pkg::fpt_div_rsp_type div_rsp;

   fpt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------------------------------------------------------- shared terms
   logic              cfg_hit;
   logic              req_fire;
   logic              div_fire;
   logic              commit_go;
   logic              div_state;
   logic [RateW-1:0]  lr_eff;
   logic [RateW-1:0]  fr_eff;
   logic [RateW-1:0]  base_rate;
   logic [CandW-1:0]  cand;
   logic [ProdW-1:0]  ms_times_sync;
   logic              fit_now;
   logic              k_last;
   logic [DurW-1:0]   quo_sat;

   assign cfg_hit  = csr_we && (csr_index == fpt_pkg::CSR_LOGIC_RATE ||
                                csr_index == fpt_pkg::CSR_FRAME_RATE ||
                                csr_index == fpt_pkg::CSR_SYNC_GROUP);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign div_fire = issued_ff && div_rsp.done;
   assign commit_go = (state_ff == fpt_pkg::S_COMMIT) && (!rsp_valid_ff || rsp_ch.ready);

   // zero selects the default rate
   assign lr_eff    = (cfg_lr_ff == '0) ? fpt_pkg::RATE_DEFAULT : cfg_lr_ff;
   assign fr_eff    = (cfg_fr_ff == '0) ? fpt_pkg::RATE_DEFAULT : cfg_fr_ff;
   assign base_rate = (fr_eff >= lr_eff) ? fr_eff : lr_eff;
   assign cand      = CandW'(base_rate) + CandW'(k_ff) * fpt_pkg::RATE_STEP;
   assign ms_times_sync = ProdW'(MS_PER_SECOND) * ProdW'(cfg_sg_ff);

   assign fit_now = lfit_ff && (div_rsp.remainder == '0);
   assign k_last  = (k_ff == fpt_pkg::RATE_TRY_LAST);
   assign quo_sat = (div_rsp.quotient[NumW-1:DurW] != '0) ? '1 : div_rsp.quotient[DurW-1:0];

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      if (cfg_hit) begin
         state_in = fpt_pkg::S_DRV_LR;
      end else begin
         case (state_ff)
            fpt_pkg::S_DRV_LR: begin
               if (div_fire) state_in = fpt_pkg::S_DRV_FR;
            end
            fpt_pkg::S_DRV_FR: begin
               if (div_fire) begin
                  state_in = (fit_now || k_last) ? fpt_pkg::S_DRV_LD : fpt_pkg::S_DRV_LR;
               end
            end
            fpt_pkg::S_DRV_LD: begin
               if (div_fire) state_in = fpt_pkg::S_DRV_GD;
            end
            fpt_pkg::S_DRV_GD: begin
               if (div_fire) state_in = fpt_pkg::S_IDLE;
            end
            fpt_pkg::S_IDLE: begin
               if (req_fire) state_in = fpt_pkg::S_LOGIC;
            end
            fpt_pkg::S_LOGIC: begin
               if (div_fire) state_in = fpt_pkg::S_FRAME;
            end
            fpt_pkg::S_FRAME: begin
               if (div_fire) state_in = fpt_pkg::S_CALC;
            end
            fpt_pkg::S_CALC: begin
               state_in = fpt_pkg::S_COMMIT;
            end
            fpt_pkg::S_COMMIT: begin
               if (commit_go) state_in = fpt_pkg::S_IDLE;
            end
            default: begin
               state_in = fpt_pkg::S_DRV_LR;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- outputs
   // Operand select for the shared divider; one launch per division state.
   always_comb begin
      div_state        = 1'b1;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      case (state_ff)
         fpt_pkg::S_DRV_LR: begin
            div_req.dividend = NumW'(cand);
            div_req.divisor  = DenW'(lr_eff);
         end
         fpt_pkg::S_DRV_FR: begin
            div_req.dividend = NumW'(cand);
            div_req.divisor  = DenW'(fr_eff);
         end
         fpt_pkg::S_DRV_LD: begin
            div_req.dividend = NumW'(MS_PER_SECOND);
            div_req.divisor  = DenW'(cand);
         end
         fpt_pkg::S_DRV_GD: begin
            div_req.dividend = NumW'(ms_times_sync);
            div_req.divisor  = DenW'(cand);
         end
         fpt_pkg::S_LOGIC: begin
            div_req.dividend = loop_count_ff;
            div_req.divisor  = li_ff;
         end
         fpt_pkg::S_FRAME: begin
            div_req.dividend = loop_count_ff;
            div_req.divisor  = fi_ff;
         end
         default: begin
            div_state = 1'b0;
         end
      endcase
      div_req.start = div_state && !issued_ff;
      req_ch.ready  = (state_ff == fpt_pkg::S_IDLE);
   end

   // ---------------------------------------------------------------- datapath
   logic [DlyW-1:0]  delay_full;    // duration + debt - elapsed, two's complement
   logic             delay_neg;
   logic             delay_over;
   logic [TimeW-1:0] debt_wrap;
   logic [TimeW-1:0] lc_new;
   logic [TimeW-1:0] logc_new;
   logic [TimeW-1:0] fc_new;
   logic [TimeW-1:0] sc_new;
   logic [GroupW-1:0] gc_new;

   always_comb begin
      delay_full = DlyW'(dur_ff)
                 + {{(DlyW-TimeW){debt_ff[TimeW-1]}}, debt_ff}
                 - {{(DlyW-TimeW){elapsed_ff[TimeW-1]}}, elapsed_ff};
      delay_neg  = delay_full[DlyW-1];
      delay_over = !delay_neg && (delay_full > DlyW'(dur_ff));
      debt_wrap  = debt_ff + elapsed_ff - TimeW'(dur_ff);
      lc_new     = loop_count_ff + 1'b1;
      logc_new   = logic_count_ff + TimeW'(logic_hit_ff);
      fc_new     = frame_count_ff + TimeW'(render_hit_ff);
      sc_new     = skip_count_ff + TimeW'(skip_ff);
      gc_new     = group_count_ff + 1'b1;

      state_in_defaults: begin
      end

      cfg_lr_in        = cfg_lr_ff;
      cfg_fr_in        = cfg_fr_ff;
      cfg_sg_in        = cfg_sg_ff;
      issued_in        = issued_ff;
      k_in             = k_ff;
      lfit_in          = lfit_ff;
      li_in            = li_ff;
      fi_in            = fi_ff;
      ld_in            = ld_ff;
      gd_in            = gd_ff;
      loop_count_in    = loop_count_ff;
      logic_count_in   = logic_count_ff;
      frame_count_in   = frame_count_ff;
      skip_count_in    = skip_count_ff;
      debt_in          = debt_ff;
      skip_in          = skip_ff;
      group_count_in   = group_count_ff;
      group_start_in   = group_start_ff;
      loop_start_in    = loop_start_ff;
      window_start_in  = window_start_ff;
      now_in           = now_ff;
      resume_in        = resume_ff;
      logic_hit_in     = logic_hit_ff;
      render_hit_in    = render_hit_ff;
      grp_in           = grp_ff;
      dur_in           = dur_ff;
      elapsed_in       = elapsed_ff;
      win_hit_in       = win_hit_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_do_logic_in  = rsp_do_logic_ff;
      rsp_do_render_in = rsp_do_render_ff;
      rsp_delay_in     = rsp_delay_ff;
      rsp_skip_next_in = rsp_skip_next_ff;
      rsp_stats_in     = rsp_stats_ff;
      rsp_loops_in     = rsp_loops_ff;
      rsp_logic_in     = rsp_logic_ff;
      rsp_frames_in    = rsp_frames_ff;
      rsp_skips_in     = rsp_skips_ff;

      // divider launch bookkeeping
      if (div_req.start) begin
         issued_in = 1'b1;
      end else if (div_fire) begin
         issued_in = 1'b0;
      end

      if (rsp_ch.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         fpt_pkg::S_DRV_LR: begin
            if (div_fire) begin
               li_in   = div_rsp.quotient[DurW-1:0];
               lfit_in = (div_rsp.remainder == '0);
            end
         end
         fpt_pkg::S_DRV_FR: begin
            if (div_fire) begin
               fi_in = div_rsp.quotient[DurW-1:0];
               if (!fit_now && !k_last) k_in = k_ff + 1'b1;
            end
         end
         fpt_pkg::S_DRV_LD: begin
            if (div_fire) ld_in = quo_sat;
         end
         fpt_pkg::S_DRV_GD: begin
            if (div_fire) gd_in = quo_sat;
         end
         fpt_pkg::S_IDLE: begin
            if (req_fire) begin
               now_in    = req_ch.now_ms;
               resume_in = req_ch.resume_ms;
            end
         end
         fpt_pkg::S_LOGIC: begin
            if (div_fire) logic_hit_in = (li_ff != '0) && (div_rsp.remainder == '0);
         end
         fpt_pkg::S_FRAME: begin
            if (div_fire) begin
               render_hit_in = !skip_ff && (fi_ff != '0) && (div_rsp.remainder == '0);
            end
         end
         fpt_pkg::S_CALC: begin
            grp_in     = gc_new >= GroupW'(cfg_sg_ff);
            dur_in     = grp_in ? gd_ff : ld_ff;
            elapsed_in = now_ff - (grp_in ? group_start_ff : loop_start_ff);
            win_hit_in = (now_ff - window_start_ff) >= TimeW'(MS_PER_SECOND);
         end
         fpt_pkg::S_COMMIT: begin
            if (commit_go) begin
               // delay or overrun
               if (delay_neg) begin
                  skip_in      = 1'b1;
                  debt_in      = debt_wrap;
                  rsp_delay_in = '0;
               end else begin
                  skip_in      = 1'b0;
                  debt_in      = '0;
                  rsp_delay_in = delay_over ? (dur_ff >> 2) : delay_full[DurW-1:0];
               end

               // resync timing
               group_count_in = grp_ff ? '0 : gc_new;
               if (grp_ff) group_start_in = resume_ff;
               loop_start_in = resume_ff;

               // one-second statistics window
               if (win_hit_ff) begin
                  rsp_loops_in    = lc_new;
                  rsp_logic_in    = logc_new;
                  rsp_frames_in   = fc_new;
                  rsp_skips_in    = sc_new;
                  loop_count_in   = '0;
                  logic_count_in  = '0;
                  frame_count_in  = '0;
                  skip_count_in   = '0;
                  window_start_in = now_ff;
               end else begin
                  rsp_loops_in    = '0;
                  rsp_logic_in    = '0;
                  rsp_frames_in   = '0;
                  rsp_skips_in    = '0;
                  loop_count_in   = lc_new;
                  logic_count_in  = logc_new;
                  frame_count_in  = fc_new;
                  skip_count_in   = sc_new;
               end

               rsp_valid_in     = 1'b1;
               rsp_do_logic_in  = logic_hit_ff;
               rsp_do_render_in = render_hit_ff;
               rsp_skip_next_in = delay_neg;
               rsp_stats_in     = win_hit_ff;
            end
         end
         default: begin
         end
      endcase

      // csr write: new value, then rerun the derivation from the first candidate
      if (cfg_hit) begin
         case (csr_index)
            fpt_pkg::CSR_LOGIC_RATE: cfg_lr_in = csr_wdata[RateW-1:0];
            fpt_pkg::CSR_FRAME_RATE: cfg_fr_in = csr_wdata[RateW-1:0];
            fpt_pkg::CSR_SYNC_GROUP: cfg_sg_in = csr_wdata[SyncW-1:0];
            default: begin
            end
         endcase
         k_in      = '0;
         issued_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= fpt_pkg::S_DRV_LR;
         issued_ff       <= 1'b0;
         cfg_lr_ff       <= fpt_pkg::RATE_DEFAULT;
         cfg_fr_ff       <= fpt_pkg::RATE_DEFAULT;
         cfg_sg_ff       <= fpt_pkg::SYNC_DEFAULT;
         k_ff            <= '0;
         loop_count_ff   <= '0;
         logic_count_ff  <= '0;
         frame_count_ff  <= '0;
         skip_count_ff   <= '0;
         debt_ff         <= '0;
         skip_ff         <= 1'b0;
         group_count_ff  <= '0;
         group_start_ff  <= '0;
         loop_start_ff   <= '0;
         window_start_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         issued_ff       <= issued_in;
         cfg_lr_ff       <= cfg_lr_in;
         cfg_fr_ff       <= cfg_fr_in;
         cfg_sg_ff       <= cfg_sg_in;
         k_ff            <= k_in;
         loop_count_ff   <= loop_count_in;
         logic_count_ff  <= logic_count_in;
         frame_count_ff  <= frame_count_in;
         skip_count_ff   <= skip_count_in;
         debt_ff         <= debt_in;
         skip_ff         <= skip_in;
         group_count_ff  <= group_count_in;
         group_start_ff  <= group_start_in;
         loop_start_ff   <= loop_start_in;
         window_start_ff <= window_start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lfit_ff          <= lfit_in;
      li_ff            <= li_in;
      fi_ff            <= fi_in;
      ld_ff            <= ld_in;
      gd_ff            <= gd_in;
      now_ff           <= now_in;
      resume_ff        <= resume_in;
      logic_hit_ff     <= logic_hit_in;
      render_hit_ff    <= render_hit_in;
      grp_ff           <= grp_in;
      dur_ff           <= dur_in;
      elapsed_ff       <= elapsed_in;
      win_hit_ff       <= win_hit_in;
      rsp_do_logic_ff  <= rsp_do_logic_in;
      rsp_do_render_ff <= rsp_do_render_in;
      rsp_delay_ff     <= rsp_delay_in;
      rsp_skip_next_ff <= rsp_skip_next_in;
      rsp_stats_ff     <= rsp_stats_in;
      rsp_loops_ff     <= rsp_loops_in;
      rsp_logic_ff     <= rsp_logic_in;
      rsp_frames_ff    <= rsp_frames_in;
      rsp_skips_ff     <= rsp_skips_in;
   end

   // ---------------------------------------------------------------- result channel
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.do_logic       = rsp_do_logic_ff;
   assign rsp_ch.do_render      = rsp_do_render_ff;
   assign rsp_ch.delay_ms       = rsp_delay_ff;
   assign rsp_ch.skip_next      = rsp_skip_next_ff;
   assign rsp_ch.stats_valid    = rsp_stats_ff;
   assign rsp_ch.loops_per_sec  = rsp_loops_ff;
   assign rsp_ch.logic_per_sec  = rsp_logic_ff;
   assign rsp_ch.frames_per_sec = rsp_frames_ff;
   assign rsp_ch.skips_per_sec  = rsp_skips_ff;

   // ---------------------------------------------------------------- assertions
   // a new result only ever comes out of the commit step
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == fpt_pkg::S_COMMIT))
      else $error("result raised outside commit");

   // an overrun never reports a wait
   a_skip_no_delay: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_skip_next_ff) |-> (rsp_delay_ff == '0))
      else $error("overrun transaction with nonzero delay");

   // statistics fields stay zero unless a window closed
   a_stats_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stats_ff) |->
         (rsp_loops_ff == '0 && rsp_logic_ff == '0 &&
          rsp_frames_ff == '0 && rsp_skips_ff == '0))
      else $error("statistics reported without a closed window");

   // no divider completion arrives while a transaction is in the calc or commit step
   a_div_single_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fpt_pkg::S_CALC || state_ff == fpt_pkg::S_COMMIT) |-> !div_rsp.done)
      else $error("stray divider completion");

endmodule

`default_nettype wire
